// File: rtl/core/ces_pkg.sv
// ----------------------------------------------------------------------------
// ces_pkg
// Shared types and constants of the center-out edge search block.
// ----------------------------------------------------------------------------
package ces_pkg;

    localparam int PIX_W = 8;               // pixel value width
    localparam int COL_W = 8;               // column index width
    localparam int RANGE_W = 7;             // search range register width
    localparam int CENTER_LEFT_DEFAULT = 93; // column just left of the row center
    localparam logic [RANGE_W-1:0] RANGE_RESET = 7'd93;
    localparam logic [COL_W-1:0] COL_MAX = 8'hFF;
    localparam int OUT_TDATA_W = 24;        // 18 result bits padded to whole bytes

    // One pixel transfer as held in the input register.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
    } pix_item_t;

    // One row result.
    typedef struct packed {
        logic             left_found;
        logic [COL_W-1:0] left_column;
        logic             right_found;
        logic [COL_W-1:0] right_column;
    } row_result_t;

endpackage

// File: rtl/core/ces_in_stage.sv
// ----------------------------------------------------------------------------
// ces_in_stage
// Input register: captures one pixel transfer per cycle while the pipe moves.
// ----------------------------------------------------------------------------
module ces_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          in_valid,
    input  ces_pkg::pix_item_t            in_item,
    output logic                          item_valid,
    output ces_pkg::pix_item_t            item
);

    logic               item_valid_reg;
    ces_pkg::pix_item_t item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (advance) begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/ces_scan.sv
// ----------------------------------------------------------------------------
// ces_scan
// Row state and transition detection; forms the row result at the last pixel.
// ----------------------------------------------------------------------------
module ces_scan #(
    parameter int CENTER_LEFT = ces_pkg::CENTER_LEFT_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          item_valid,
    input  ces_pkg::pix_item_t            item,
    input  logic [ces_pkg::RANGE_W-1:0]   search_range,
    output logic                          res_valid,
    output ces_pkg::row_result_t          res
);

    localparam logic [ces_pkg::COL_W-1:0] CenterCol = ces_pkg::COL_W'(CENTER_LEFT);
    localparam logic [ces_pkg::COL_W:0]   RightStart = (ces_pkg::COL_W + 1)'(CENTER_LEFT + 2);

    logic [ces_pkg::PIX_W-1:0] prev_pixel_reg, prev_pixel_next;
    logic [ces_pkg::COL_W-1:0] col_reg, col_next;
    logic                      left_hit_reg, left_hit_next;
    logic [ces_pkg::COL_W-1:0] left_col_reg, left_col_next;
    logic                      right_hit_reg, right_hit_next;
    logic [ces_pkg::COL_W-1:0] right_col_reg, right_col_next;

    logic                      step;
    logic                      differs;
    logic [ces_pkg::COL_W-1:0] range_ext;
    logic [ces_pkg::COL_W-1:0] left_start;
    logic [ces_pkg::COL_W:0]   right_end_wide;
    logic [ces_pkg::COL_W-1:0] right_end;
    logic                      left_take;
    logic                      right_take;
    logic                      left_hit_upd, right_hit_upd;
    logic [ces_pkg::COL_W-1:0] left_col_upd, right_col_upd;

    assign step      = advance && item_valid;
    assign range_ext = {1'b0, search_range};

    // Window bounds; the left start clips at column 0, the right end at 255.
    assign left_start     = (CenterCol >= range_ext) ? (CenterCol - range_ext) : '0;
    assign right_end_wide = (ces_pkg::COL_W + 1)'(CENTER_LEFT) + 1'b1 + {2'b00, search_range};
    assign right_end      = right_end_wide[ces_pkg::COL_W] ? ces_pkg::COL_MAX
                                                           : right_end_wide[ces_pkg::COL_W-1:0];

    assign differs    = (col_reg != '0) && (item.pixel != prev_pixel_reg);
    assign left_take  = differs && ((col_reg - 1'b1) >= left_start) && (col_reg <= CenterCol);
    assign right_take = differs && !right_hit_reg && ({1'b0, col_reg} >= RightStart)
                        && (col_reg <= right_end);

    // The left side keeps the latest hit, the right side the first one.
    assign left_hit_upd  = left_hit_reg || left_take;
    assign left_col_upd  = left_take ? (col_reg - 1'b1) : left_col_reg;
    assign right_hit_upd = right_hit_reg || right_take;
    assign right_col_upd = right_take ? col_reg : right_col_reg;

    always_comb begin
        prev_pixel_next = prev_pixel_reg;
        col_next        = col_reg;
        left_hit_next   = left_hit_reg;
        left_col_next   = left_col_reg;
        right_hit_next  = right_hit_reg;
        right_col_next  = right_col_reg;
        if (step) begin
            if (item.row_end) begin
                prev_pixel_next = '0;
                col_next        = '0;
                left_hit_next   = 1'b0;
                left_col_next   = '0;
                right_hit_next  = 1'b0;
                right_col_next  = '0;
            end else begin
                prev_pixel_next = item.pixel;
                col_next        = (col_reg == ces_pkg::COL_MAX) ? col_reg : col_reg + 1'b1;
                left_hit_next   = left_hit_upd;
                left_col_next   = left_col_upd;
                right_hit_next  = right_hit_upd;
                right_col_next  = right_col_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pixel_reg <= '0;
            col_reg        <= '0;
            left_hit_reg   <= 1'b0;
            left_col_reg   <= '0;
            right_hit_reg  <= 1'b0;
            right_col_reg  <= '0;
        end else begin
            prev_pixel_reg <= prev_pixel_next;
            col_reg        <= col_next;
            left_hit_reg   <= left_hit_next;
            left_col_reg   <= left_col_next;
            right_hit_reg  <= right_hit_next;
            right_col_reg  <= right_col_next;
        end
    end

    assign res_valid        = step && item.row_end;
    assign res.left_found   = left_hit_upd;
    assign res.left_column  = left_hit_upd ? left_col_upd : left_start;
    assign res.right_found  = right_hit_upd;
    assign res.right_column = right_hit_upd ? right_col_upd : right_end;

    // A finished row always restarts at column 0 with no hits.
    a_row_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (col_reg == '0) && !left_hit_reg && !right_hit_reg)
        else $error("row state not cleared after row end");

    // Inside a row the column advances by one until it saturates.
    a_col_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !item.row_end && (col_reg != ces_pkg::COL_MAX))
        |=> (col_reg == $past(col_reg) + 1'b1))
        else $error("column count did not advance");

    // A right hit never lies at or left of the center pair.
    a_right_side: assert property (@(posedge aclk) disable iff (!aresetn)
        right_hit_reg |-> ({1'b0, right_col_reg} >= RightStart))
        else $error("right hit column left of the right window");

    // A left hit never lies right of the center column.
    a_left_side: assert property (@(posedge aclk) disable iff (!aresetn)
        left_hit_reg |-> (left_col_reg < CenterCol))
        else $error("left hit column right of the left window");

endmodule

// File: rtl/core/ces_out_reg.sv
// ----------------------------------------------------------------------------
// ces_out_reg
// Result register: holds one row result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ces_out_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               res_valid,
    input  ces_pkg::row_result_t               res,
    output logic                               advance,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ces_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int ResW = $bits(ces_pkg::row_result_t);

    logic                               valid_reg;
    logic [ces_pkg::OUT_TDATA_W-1:0]    data_reg;

    // The pipe moves whenever the result slot is empty or being emptied.
    assign advance = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            data_reg <= {{(ces_pkg::OUT_TDATA_W - ResW){1'b0}},
                         res.right_column, res.right_found,
                         res.left_column, res.left_found};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: rtl/core/center_out_edge_search.sv
// ----------------------------------------------------------------------------
// center_out_edge_search
// Finds the pixel transition nearest the row center on each side of a row.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Transfer
//  s_*       in         pixel in tdata[7:0], row end in tlast    tvalid & tready
//  m_*       out        one row result in tdata[17:0]            tvalid & tready
//  cfg_*     in         search_range in cfg_data[6:0]            cfg_valid & cfg_ready
//
//  One pixel is taken every clock cycle while s_tready is high; a row result is
//  presented once the row's last pixel has passed the input register and its
//  result has been loaded into the result register.
//  Reset clears the row state and loads search_range with 93.
//  Input and output are parted by the result register: s_tready only falls
//  while a result is held and m_tready is low, so pixels keep flowing while the
//  downstream side is ready or the result slot is empty.
//  cfg_ready is always high; the range is meant to be written between rows.
//
// The left side scans pixel pairs whose lower column lies from
// CENTER_LEFT-search_range to CENTER_LEFT-1 and reports the lower column of the
// pair nearest the center. The right side scans pairs whose higher column lies
// from CENTER_LEFT+2 to CENTER_LEFT+1+search_range and reports the higher
// column. The pair straddling the center is never examined. A side without a
// transition reports its window end with its found flag cleared.
// ----------------------------------------------------------------------------
module center_out_edge_search #(
    parameter int CENTER_LEFT = ces_pkg::CENTER_LEFT_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ces_pkg::PIX_W-1:0]         s_tdata,   // [7:0] pixel
    input  logic                              s_tlast,   // row end

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] left_found, [8:1] left_column, [9] right_found, [17:10] right_column,
    // [23:18] zero
    output logic [ces_pkg::OUT_TDATA_W-1:0]   m_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ces_pkg::RANGE_W-1:0]       cfg_data   // [6:0] search_range
);

    logic                          advance;
    logic                          item_valid;
    ces_pkg::pix_item_t            in_item;
    ces_pkg::pix_item_t            item;
    logic                          res_valid;
    ces_pkg::row_result_t          res;
    logic [ces_pkg::RANGE_W-1:0]   search_range_reg;

    // Configuration register: always ready, one write per transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_range_reg <= ces_pkg::RANGE_RESET;
        end else if (cfg_valid) begin
            search_range_reg <= cfg_data;
        end
    end

    // The whole pipe moves together, gated only by the result register.
    assign s_tready = advance;

    assign in_item.pixel   = s_tdata;
    assign in_item.row_end = s_tlast;

    ces_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (s_tvalid),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item)
    );

    ces_scan #(
        .CENTER_LEFT (CENTER_LEFT)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item),
        .search_range (search_range_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    ces_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
